@@ src/ple_pkg.sv @@
// Shared types, codes and sizes of the positional list engine.
package ple_pkg;

  localparam int Depth = 64;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam int PosW = 7;
  localparam int LenW = 7;
  localparam int DataW = 32;
  localparam int CmpW = ((PosW > CntW) ? PosW : CntW) + 1;
  localparam int QDepth = 2;
  localparam int QPtrW = $clog2(QDepth);
  localparam int QCntW = $clog2(QDepth + 1);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_GET = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    KIND_ERR = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_GET = 2'd2,
    KIND_DELETE = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic [AddrW-1:0] idx;
    logic [CntW-1:0] cnt;
    logic [DataW-1:0] value;
    logic [1:0] status;
    logic [LenW-1:0] length;
  } entry_t;

endpackage

@@ src/ple_front.sv @@
// Front end: checks each request against the running count and classifies it.
module ple_front (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  logic [1:0] mode,
  input  logic [ple_pkg::PosW-1:0] position,
  input  logic [ple_pkg::DataW-1:0] value,
  output ple_pkg::entry_t entry
);

  logic [ple_pkg::CntW-1:0] count_r;
  logic [ple_pkg::CntW-1:0] count_nxt;
  logic [ple_pkg::CmpW-1:0] pos_w;
  logic [ple_pkg::CmpW-1:0] cnt_w;

  assign pos_w = ple_pkg::CmpW'(position);
  assign cnt_w = ple_pkg::CmpW'(count_r);

  always_comb begin
    count_nxt = count_r;
    entry.kind = ple_pkg::KIND_ERR;
    entry.status = ple_pkg::ST_BADPOS;
    entry.idx = ple_pkg::AddrW'(pos_w - ple_pkg::CmpW'(1));
    entry.cnt = count_r;
    entry.value = value;
    unique case (mode)
      ple_pkg::MODE_INSERT: begin
        if (pos_w == '0 || pos_w > cnt_w + ple_pkg::CmpW'(1)) begin
          entry.status = ple_pkg::ST_BADPOS;
        end else if (cnt_w >= ple_pkg::CmpW'(ple_pkg::Depth)) begin
          entry.status = ple_pkg::ST_FULL;
        end else begin
          entry.status = ple_pkg::ST_OK;
          entry.kind = ple_pkg::KIND_INSERT;
          count_nxt = count_r + ple_pkg::CntW'(1);
        end
      end
      ple_pkg::MODE_GET: begin
        if (pos_w != '0 && pos_w <= cnt_w) begin
          entry.status = ple_pkg::ST_OK;
          entry.kind = ple_pkg::KIND_GET;
        end
      end
      ple_pkg::MODE_DELETE: begin
        if (pos_w != '0 && pos_w <= cnt_w) begin
          entry.status = ple_pkg::ST_OK;
          entry.kind = ple_pkg::KIND_DELETE;
          count_nxt = count_r - ple_pkg::CntW'(1);
        end
      end
      default: begin
        entry.status = ple_pkg::ST_BADPOS;
      end
    endcase
    entry.length = ple_pkg::LenW'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ src/ple_queue.sv @@
// Short queue of classified requests between the front and the back end.
module ple_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  ple_pkg::entry_t push_data,
  input  logic pop,
  output ple_pkg::entry_t pop_data,
  output logic empty,
  output logic full
);

  ple_pkg::entry_t slot_r [ple_pkg::QDepth];
  logic [ple_pkg::QPtrW-1:0] wr_ptr_r;
  logic [ple_pkg::QPtrW-1:0] rd_ptr_r;
  logic [ple_pkg::QCntW-1:0] fill_r;
  logic do_push;
  logic do_pop;

  assign empty = (fill_r == '0);
  assign full = (fill_r == ple_pkg::QCntW'(ple_pkg::QDepth));
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == ple_pkg::QPtrW'(ple_pkg::QDepth - 1)) ? '0
                    : wr_ptr_r + ple_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == ple_pkg::QPtrW'(ple_pkg::QDepth - 1)) ? '0
                    : rd_ptr_r + ple_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + ple_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - ple_pkg::QCntW'(1);
      end
    end
  end

endmodule

@@ src/ple_back.sv @@
// Back end: carries out requests on the entry memory and registers each result.
module ple_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  ple_pkg::entry_t q_data,
  output logic q_pop,
  output logic out_strobe,
  output logic [ple_pkg::DataW-1:0] out_value,
  output logic [1:0] out_status,
  output logic [ple_pkg::LenW-1:0] out_length
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN = 3'b010,
    S_WAIT = 3'b100
  } state_t;

  logic [ple_pkg::DataW-1:0] mem [ple_pkg::Depth];
  logic [ple_pkg::DataW-1:0] rd_data_r;
  logic [ple_pkg::AddrW-1:0] rd_addr;
  logic mem_we;
  logic [ple_pkg::AddrW-1:0] mem_waddr;
  logic [ple_pkg::DataW-1:0] mem_wdata;

  state_t state_r, state_nxt;
  ple_pkg::entry_t ent_r, ent_nxt;
  logic [ple_pkg::AddrW-1:0] k_r, k_nxt;
  logic first_r, first_nxt;
  logic [ple_pkg::DataW-1:0] res_r, res_nxt;
  logic strobe_r, strobe_nxt;
  logic [ple_pkg::DataW-1:0] value_r, value_nxt;
  logic [1:0] status_r, status_nxt;
  logic [ple_pkg::LenW-1:0] length_r, length_nxt;
  logic [ple_pkg::CntW-1:0] k_next_w;

  assign k_next_w = ple_pkg::CntW'(k_r) + ple_pkg::CntW'(1);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    ent_nxt = ent_r;
    k_nxt = k_r;
    first_nxt = first_r;
    res_nxt = res_r;
    q_pop = 1'b0;
    mem_we = 1'b0;
    mem_waddr = k_r;
    mem_wdata = rd_data_r;
    rd_addr = k_r;
    strobe_nxt = 1'b0;
    value_nxt = value_r;
    status_nxt = status_r;
    length_nxt = length_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          ent_nxt = q_data;
          k_nxt = (q_data.kind == ple_pkg::KIND_INSERT) ?
                  q_data.cnt[ple_pkg::AddrW-1:0] : q_data.idx;
          first_nxt = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        unique case (ent_r.kind)
          ple_pkg::KIND_ERR: begin
            strobe_nxt = 1'b1;
            value_nxt = '0;
            state_nxt = S_IDLE;
          end
          ple_pkg::KIND_GET: begin
            rd_addr = ent_r.idx;
            state_nxt = S_WAIT;
          end
          ple_pkg::KIND_INSERT: begin
            if (k_r == ent_r.idx) begin
              mem_we = 1'b1;
              mem_waddr = ent_r.idx;
              mem_wdata = ent_r.value;
              strobe_nxt = 1'b1;
              value_nxt = '0;
              state_nxt = S_IDLE;
            end else begin
              rd_addr = k_r - ple_pkg::AddrW'(1);
              state_nxt = S_WAIT;
            end
          end
          ple_pkg::KIND_DELETE: begin
            if (first_r) begin
              rd_addr = k_r;
              state_nxt = S_WAIT;
            end else if (k_next_w < ent_r.cnt) begin
              rd_addr = k_next_w[ple_pkg::AddrW-1:0];
              state_nxt = S_WAIT;
            end else begin
              strobe_nxt = 1'b1;
              value_nxt = res_r;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
        status_nxt = ent_r.status;
        length_nxt = ent_r.length;
      end
      S_WAIT: begin
        state_nxt = S_RUN;
        unique case (ent_r.kind)
          ple_pkg::KIND_GET: begin
            strobe_nxt = 1'b1;
            value_nxt = rd_data_r;
            status_nxt = ent_r.status;
            length_nxt = ent_r.length;
            state_nxt = S_IDLE;
          end
          ple_pkg::KIND_INSERT: begin
            mem_we = 1'b1;
            k_nxt = k_r - ple_pkg::AddrW'(1);
          end
          ple_pkg::KIND_DELETE: begin
            if (first_r) begin
              res_nxt = rd_data_r;
              first_nxt = 1'b0;
            end else begin
              mem_we = 1'b1;
              k_nxt = k_next_w[ple_pkg::AddrW-1:0];
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    k_r <= k_nxt;
    first_r <= first_nxt;
    res_r <= res_nxt;
    value_r <= value_nxt;
    status_r <= status_nxt;
    length_r <= length_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_value = value_r;
  assign out_status = status_r;
  assign out_length = length_r;

endmodule

@@ src/positional_list_engine.sv @@
// Top level of the positional list engine: front end, request queue and back end.
//
// A request beat (in_mode, in_position, in_value_in) is taken at a rising edge
// where start is high and busy is low. Modes are insert, get and delete at a
// 1-based position. Every request yields one result beat on out_value_out,
// out_status and out_length, marked by out_strobe for one cycle.
// The front end checks the position against the running count at once and
// queues the classified request; busy is high while the two-entry queue is full.
// The back end works on one request at a time against a single entry memory
// with a registered read; each entry that it moves is read in S_RUN and written in S_WAIT.
// An insert moves the entries from the position to the end up by one place,
// last first, then writes the new value; a delete reads the entry at the
// position for its result, then moves the entries behind it down by one.
// Synchronous reset empties the list and the queue and drops pending results.
// The receiver cannot stall; results come out in request order.
module positional_list_engine (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [1:0] in_mode,
  input  logic [ple_pkg::PosW-1:0] in_position,
  input  logic signed [ple_pkg::DataW-1:0] in_value_in,
  output logic out_strobe,
  output logic signed [ple_pkg::DataW-1:0] out_value_out,
  output logic [1:0] out_status,
  output logic [ple_pkg::LenW-1:0] out_length
);

  logic accept;
  logic q_full;
  logic q_empty;
  logic q_pop;
  ple_pkg::entry_t front_entry;
  ple_pkg::entry_t q_data;
  logic [ple_pkg::DataW-1:0] back_value;

  assign busy = q_full;
  assign accept = start && !q_full;

  ple_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .accept(accept),
    .mode(in_mode),
    .position(in_position),
    .value(in_value_in),
    .entry(front_entry)
  );

  ple_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(accept),
    .push_data(front_entry),
    .pop(q_pop),
    .pop_data(q_data),
    .empty(q_empty),
    .full(q_full)
  );

  ple_back u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_empty(q_empty),
    .q_data(q_data),
    .q_pop(q_pop),
    .out_strobe(out_strobe),
    .out_value(back_value),
    .out_status(out_status),
    .out_length(out_length)
  );

  assign out_value_out = back_value;

`ifndef SYNTHESIS
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("result beat right after reset");
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != ple_pkg::ST_OK |-> out_value_out == '0)
    else $error("failed request returned a nonzero value");
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status == ple_pkg::ST_FULL |->
      out_length == ple_pkg::LenW'(ple_pkg::Depth))
    else $error("full status with a list that is not full");
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> {1'b0, out_length} <= (ple_pkg::LenW + 1)'(ple_pkg::Depth))
    else $error("length beyond the list depth");
`endif

endmodule
